/* hdl/tkmq_pkg.sv */
// Shared constants and types for the timestamp k-way merge queue.
package tkmq_pkg;

  localparam int NUM_SOURCES_DEF = 16;
  localparam int CMD_W           = 2;
  localparam int SOURCE_W        = 4;
  localparam int STAMP_W         = 64;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [SOURCE_W-1:0] source_t;
  typedef logic [STAMP_W-1:0]  stamp_t;

  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_POP    = 2'd2;
  localparam cmd_t CMD_PEEK   = 2'd3;

endpackage

/* hdl/timestamp_kway_merge_queue_unit.sv */
// Clear and insert: item accepted, result strobe in the following cycle, busy stays low.
// Pop and peek: busy rises on accept and the result strobe follows the end of the scan;
// the minimum search walks the stamp memory through its single read port, one entry a cycle.
// busy drops with the result strobe; no new command is accepted before then.
// Synchronous active-low reset empties every slot and leaves the unit idle.
// Results cannot be stalled: each result sits on out_* for exactly one cycle.
module timestamp_kway_merge_queue_unit #(
  parameter int NUM_SOURCES = tkmq_pkg::NUM_SOURCES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tkmq_pkg::cmd_t    in_command,
  input  tkmq_pkg::source_t in_source,
  input  tkmq_pkg::stamp_t  in_stamp,
  output logic              out_valid,
  output logic              out_found,
  output tkmq_pkg::source_t out_winner,
  output tkmq_pkg::stamp_t  out_winner_stamp
);
  import tkmq_pkg::*;

  localparam int SRC_W = $clog2(NUM_SOURCES);
  localparam int CNT_W = SRC_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;

  // head timestamps; only valid where the present bit is set
  stamp_t mem [NUM_SOURCES];
  stamp_t rd_data_r;
  logic   mem_we;
  logic   [SRC_W-1:0] mem_waddr;
  logic   [SRC_W-1:0] mem_raddr;

  logic [NUM_SOURCES-1:0] present_r, present_nxt;

  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [SRC_W-1:0] rd_idx_r, rd_idx_nxt;

  logic             any_r, any_nxt;
  logic [SRC_W-1:0] best_idx_r, best_idx_nxt;
  stamp_t           best_stamp_r, best_stamp_nxt;
  logic             is_pop_r, is_pop_nxt;

  logic    out_valid_r, out_valid_nxt;
  logic    out_found_r, out_found_nxt;
  source_t out_winner_r, out_winner_nxt;
  stamp_t  out_stamp_r, out_stamp_nxt;

  logic accept;
  logic src_ok;
  logic scan_done;

  assign accept    = start && (state_r == ST_IDLE);
  assign src_ok    = (32'(in_source) < 32'(NUM_SOURCES));
  assign mem_waddr = SRC_W'(in_source);
  assign mem_we    = accept && (in_command == CMD_INSERT) && src_ok;
  assign mem_raddr = rd_cnt_r[SRC_W-1:0];
  assign scan_done = (rd_cnt_r == CNT_W'(NUM_SOURCES)) && !rd_vld_r;

  // writes happen only while idle and read data is used only while scanning, so no overlap
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_stamp;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt      = state_r;
    present_nxt    = present_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    any_nxt        = any_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    is_pop_nxt     = is_pop_r;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = 1'b0;
    out_winner_nxt = '0;
    out_stamp_nxt  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_command) inside
            CMD_CLEAR: begin
              present_nxt   = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_INSERT: begin
              if (src_ok) begin
                present_nxt[mem_waddr] = 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            CMD_POP, CMD_PEEK: begin
              state_nxt    = ST_SCAN;
              rd_cnt_nxt   = '0;
              any_nxt      = 1'b0;
              best_idx_nxt = '0;
              is_pop_nxt   = (in_command == CMD_POP);
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (rd_cnt_r != CNT_W'(NUM_SOURCES)) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_cnt_r[SRC_W-1:0];
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        // compare the entry read last cycle; strict less keeps the lower index on ties
        if (rd_vld_r && present_r[rd_idx_r]) begin
          if (!any_r || (rd_data_r < best_stamp_r)) begin
            any_nxt        = 1'b1;
            best_idx_nxt   = rd_idx_r;
            best_stamp_nxt = rd_data_r;
          end
        end
        if (scan_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (any_r) begin
            out_found_nxt  = 1'b1;
            out_winner_nxt = SOURCE_W'(best_idx_r);
            out_stamp_nxt  = best_stamp_r;
            if (is_pop_r) begin
              present_nxt[best_idx_r] = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    is_pop_r     <= is_pop_nxt;
    out_found_r  <= out_found_nxt;
    out_winner_r <= out_winner_nxt;
    out_stamp_r  <= out_stamp_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_winner       = out_winner_r;
  assign out_winner_stamp = out_stamp_r;

endmodule
